FILE: sv/kci_pkg.sv
// Shared types and constants for the keyframe camera interpolator.
// Used by the channel interfaces, the keyframe memory, the lerp unit, the divider and the top level.
// Depends on nothing.
package kci_pkg;

    // Default table depth. The top level hands its own parameter down.
    localparam int KCI_KEYFRAMES = 8;

    localparam int COORD_W    = 32;   // Q16.16 signed coordinate
    localparam int NUM_COMP   = 6;    // eye x/y/z then look-at x/y/z
    localparam int COMP_IDX_W = $clog2(NUM_COMP);
    localparam int DUR_W      = 16;
    localparam int CNT_W      = 17;
    localparam int SLOT_W     = 3;

    localparam logic [DUR_W-1:0] DEFAULT_DURATION = 16'd60;

    // Lerp arithmetic. The magnitude of (next - cur) is held in 33 bits. Times a
    // 17-bit count it needs 50 bits. The dividend is padded to whole digits.
    localparam int MAG_W       = 33;
    localparam int PROD_W      = 50;
    localparam int DIV_DIGIT_W = 8;
    localparam int DIV_W       = 56;
    localparam int DIV_STEPS   = DIV_W / DIV_DIGIT_W;
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);
    localparam int SUM_W       = DIV_W + 2;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord COORD_MAX = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN = 32'sh8000_0000;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // One keyframe entry. Coordinates are held in component order.
    typedef struct packed {
        t_coord [NUM_COMP-1:0] coord;
        logic   [DUR_W-1:0]    duration;
    } t_key;

endpackage

FILE: sv/kci_if.sv
// Valid/ready channel interfaces for the keyframe camera interpolator.
// Depends on kci_pkg.
interface kci_in_if import kci_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [SLOT_W-1:0]  slot;
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] look_x;
    logic signed [COORD_W-1:0] look_y;
    logic signed [COORD_W-1:0] look_z;
    logic [DUR_W-1:0]   duration;

    modport source (
        output valid, operation, slot, eye_x, eye_y, eye_z,
               look_x, look_y, look_z, duration,
        input  ready
    );
    modport sink (
        input  valid, operation, slot, eye_x, eye_y, eye_z,
               look_x, look_y, look_z, duration,
        output ready
    );
endinterface

interface kci_out_if import kci_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [COORD_W-1:0] cam_eye_x;
    logic signed [COORD_W-1:0] cam_eye_y;
    logic signed [COORD_W-1:0] cam_eye_z;
    logic signed [COORD_W-1:0] cam_look_x;
    logic signed [COORD_W-1:0] cam_look_y;
    logic signed [COORD_W-1:0] cam_look_z;
    logic moved;
    logic finished;

    modport source (
        output valid, cam_eye_x, cam_eye_y, cam_eye_z,
               cam_look_x, cam_look_y, cam_look_z, moved, finished,
        input  ready
    );
    modport sink (
        input  valid, cam_eye_x, cam_eye_y, cam_eye_z,
               cam_look_x, cam_look_y, cam_look_z, moved, finished,
        output ready
    );
endinterface

FILE: sv/keyframe_camera_interpolator.sv
// Keyframe camera interpolator, top level.
// A write item, or a tick once the sequence is finished, goes from acceptance to S_DONE and
// then to the output register. A moving tick makes two keyframe memory reads, then takes six
// components one by one through the shared lerp unit (eight quotient bits a cycle).
// One item is worked on at a time; the next is accepted while the last result waits.
// Reset (synchronous, active low) clears phase, tick count, keyframe valid bits and the FSM.
module keyframe_camera_interpolator import kci_pkg::*; #(
    parameter int KEYFRAMES = KCI_KEYFRAMES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kci_in_if.sink    i_in,
    kci_out_if.source o_out
);

    localparam int AW = $clog2(KEYFRAMES);

    // Control flow for one item:
    //   S_IDLE   : ready is high. A write item goes straight to the memory and to S_DONE.
    //              A tick item that still has work to do starts the read of the current
    //              keyframe. A finished tick goes straight to S_DONE.
    //   S_RD_CUR : the current keyframe is on the read port. It is latched here and
    //              the read of the next keyframe starts. That entry then stays on the
    //              read port for the rest of the item.
    //   S_START  : starts the lerp unit on the component picked by r_k.
    //   S_WAIT   : waits for the lerp result. After the last component it updates
    //              the tick count and the phase.
    //   S_DONE   : hands the result to the output register as soon as that is free.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_CUR,
        S_START,
        S_WAIT,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [AW-1:0]              r_phase;
    logic [CNT_W-1:0]           r_tick;
    logic [COMP_IDX_W-1:0]      r_k;
    t_key                       r_cur_key;
    logic [DUR_W-1:0]           r_dur;
    t_coord [NUM_COMP-1:0]      r_res;
    logic                       r_res_moved;
    logic                       r_res_fin;
    logic                       r_out_valid;
    t_coord [NUM_COMP-1:0]      r_out_coord;
    logic                       r_out_moved;
    logic                       r_out_fin;

    logic                       w_accept;
    logic                       w_is_write;
    logic                       w_done;
    logic                       w_slot_ok;
    logic [SLOT_W+AW-1:0]       w_slot_ext;
    logic                       w_wr_en;
    t_key                       w_wr_key;
    logic                       w_rd_en;
    logic [AW-1:0]              w_rd_addr;
    t_key                       w_rd_key;
    logic                       w_lerp_done;
    t_coord                     w_lerp_res;
    logic [CNT_W-1:0]           w_cnt_next;
    logic                       w_out_free;

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_is_write = (i_in.operation == OP_WRITE);

    // The sequence is complete once the phase has reached the last keyframe.
    assign w_done = (32'(r_phase) >= 32'(KEYFRAMES - 1));

    // A slot beyond the table is dropped silently, though the item still gets its result.
    assign w_slot_ok  = (32'(i_in.slot) < 32'(KEYFRAMES));
    assign w_slot_ext = {{AW{1'b0}}, i_in.slot};
    assign w_wr_en    = w_accept && w_is_write && w_slot_ok;

    assign w_wr_key.coord[0] = i_in.eye_x;
    assign w_wr_key.coord[1] = i_in.eye_y;
    assign w_wr_key.coord[2] = i_in.eye_z;
    assign w_wr_key.coord[3] = i_in.look_x;
    assign w_wr_key.coord[4] = i_in.look_y;
    assign w_wr_key.coord[5] = i_in.look_z;
    assign w_wr_key.duration = i_in.duration;

    // The current keyframe is read when the item is accepted, and the next one in the cycle after.
    // Writes and reads never overlap, because only one item is in flight at a time.
    assign w_rd_en   = (w_accept && !w_is_write && !w_done) || (r_state == S_RD_CUR);
    assign w_rd_addr = (r_state == S_RD_CUR) ? (r_phase + AW'(1)) : r_phase;

    kci_key_mem #(
        .KEYFRAMES (KEYFRAMES)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_slot_ext[AW-1:0]),
        .i_wr_key  (w_wr_key),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_key  (w_rd_key)
    );

    // ------------------------------------------------------------------
    // Shared lerp unit. It works on one component at a time: the current keyframe
    // is in r_cur_key and the next keyframe is held on the memory read port.
    // ------------------------------------------------------------------
    kci_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_cur   (r_cur_key.coord[r_k]),
        .i_nxt   (w_rd_key.coord[r_k]),
        .i_cnt   (r_tick),
        .i_dur   (r_dur),
        .o_done  (w_lerp_done),
        .o_res   (w_lerp_res)
    );

    // The 17-bit tick count never wraps; the phase advances once the count passes the duration.
    assign w_cnt_next = r_tick + CNT_W'(1);
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_tick      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        // Coordinates stay zero for write items and finished ticks.
                        r_res       <= '0;
                        r_res_moved <= 1'b0;
                        r_res_fin   <= w_done;
                        r_k         <= '0;
                        if (!w_is_write && !w_done) begin
                            r_state <= S_RD_CUR;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RD_CUR: begin
                    r_cur_key <= w_rd_key;
                    // A zero duration counts as one, for the fraction and the end test alike.
                    r_dur     <= (w_rd_key.duration == '0) ? DUR_W'(1) : w_rd_key.duration;
                    r_state   <= S_START;
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_lerp_done) begin
                        r_res[r_k] <= w_lerp_res;
                        if (r_k == COMP_IDX_W'(NUM_COMP - 1)) begin
                            r_res_moved <= 1'b1;
                            if (w_cnt_next > {1'b0, r_dur}) begin
                                r_tick  <= '0;
                                r_phase <= r_phase + AW'(1);
                            end else begin
                                r_tick <= w_cnt_next;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_k     <= r_k + COMP_IDX_W'(1);
                            r_state <= S_START;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_coord <= r_res;
                        r_out_moved <= r_res_moved;
                        r_out_fin   <= r_res_fin;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    assign o_out.valid      = r_out_valid;
    assign o_out.cam_eye_x  = r_out_coord[0];
    assign o_out.cam_eye_y  = r_out_coord[1];
    assign o_out.cam_eye_z  = r_out_coord[2];
    assign o_out.cam_look_x = r_out_coord[3];
    assign o_out.cam_look_y = r_out_coord[4];
    assign o_out.cam_look_z = r_out_coord[5];
    assign o_out.moved      = r_out_moved;
    assign o_out.finished   = r_out_fin;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The phase only ever steps forward by one keyframe.
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_phase != $past(r_phase))) |-> (r_phase == $past(r_phase) + AW'(1)))
        else $error("phase moved by other than one step");

    // A lerp result only arrives while the sequencer is waiting for one.
    a_lerp_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lerp_done |-> (r_state == S_WAIT))
        else $error("lerp result outside the wait state");

    // A result that did not move the camera carries zero coordinates.
    a_still_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.moved) |->
            (o_out.cam_eye_x == '0 && o_out.cam_eye_y == '0 && o_out.cam_eye_z == '0 &&
             o_out.cam_look_x == '0 && o_out.cam_look_y == '0 && o_out.cam_look_z == '0))
        else $error("non-moving result with non-zero pose");

    // A finished sequence never reports movement.
    a_fin_not_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.moved && o_out.finished))
        else $error("result both moved and finished");

endmodule

FILE: sv/kci_key_mem.sv
// Keyframe table: one synchronous memory with one write and one registered read port.
// Durations read as the default until their slot is first written.
// Depends on kci_pkg.
module kci_key_mem import kci_pkg::*; #(
    parameter int KEYFRAMES = KCI_KEYFRAMES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [$clog2(KEYFRAMES)-1:0] i_wr_addr,
    input  t_key                         i_wr_key,
    input  logic                         i_rd_en,
    input  logic [$clog2(KEYFRAMES)-1:0] i_rd_addr,
    output t_key                         o_rd_key
);

    t_key                 r_mem [KEYFRAMES];
    logic [KEYFRAMES-1:0] r_valid;
    t_key                 r_rd_key;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_rd_en) begin
            r_rd_key <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // Coordinates of a slot never written are left as they are.
    always_comb begin
        o_rd_key          = r_rd_key;
        o_rd_key.duration = r_rd_valid ? r_rd_key.duration : DEFAULT_DURATION;
    end

endmodule

FILE: sv/kci_div.sv
// Unsigned iterative divider, one eight-bit quotient digit per cycle.
// Divides the lerp product magnitude by the keyframe duration. Depends on kci_pkg.
module kci_div import kci_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_dividend,
    input  logic [DUR_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [DIV_W-1:0]   o_quo
);

    logic [DIV_W-1:0]      r_work;
    logic [DUR_W-1:0]      r_rem;
    logic [DIV_STEP_W-1:0] r_step;
    logic                  r_busy;
    logic                  r_done;

    logic [DIV_W-1:0]      w_work;
    logic [DUR_W-1:0]      w_rem;
    logic [DUR_W:0]        w_trial;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    // The remainder always stays below the divisor, so it fits in the divisor width.
    always_comb begin
        w_work  = r_work;
        w_rem   = r_rem;
        w_trial = '0;
        for (int i = 0; i < DIV_DIGIT_W; i++) begin
            w_trial = {w_rem, w_work[DIV_W-1]};
            w_work  = {w_work[DIV_W-2:0], 1'b0};
            if (w_trial >= {1'b0, i_divisor}) begin
                w_trial   = w_trial - {1'b0, i_divisor};
                w_work[0] = 1'b1;
            end
            w_rem = w_trial[DUR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_work <= i_dividend;
                r_rem  <= '0;
                r_step <= DIV_STEP_W'(DIV_STEPS - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_work <= w_work;
                r_rem  <= w_rem;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - DIV_STEP_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_work;

endmodule

FILE: sv/kci_lerp.sv
// Lerp unit for one coordinate: cur + trunc((next - cur) * count / duration), saturated.
// Holds the multiplier and the iterative divider. Depends on kci_pkg and kci_div.
module kci_lerp import kci_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_coord           i_cur,
    input  t_coord           i_nxt,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic [DUR_W-1:0] i_dur,
    output logic             o_done,
    output t_coord           o_res
);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_DIV_GO,
        L_DIV_WAIT,
        L_SUM
    } t_lstate;

    t_lstate             r_state;
    logic [MAG_W-1:0]    r_mag;
    logic                r_neg;
    t_coord              r_cur;
    logic [PROD_W-1:0]   r_prod;
    logic                r_done;
    t_coord              r_res;

    logic signed [MAG_W-1:0] w_diff;
    logic [MAG_W-1:0]        w_abs;
    logic                    w_div_done;
    logic [DIV_W-1:0]        w_quo;
    logic signed [SUM_W-1:0] w_cur_s;
    logic signed [SUM_W-1:0] w_quo_s;
    logic signed [SUM_W-1:0] w_sum;
    t_coord                  w_sat;

    assign w_diff = MAG_W'(i_nxt) - MAG_W'(i_cur);
    assign w_abs  = w_diff[MAG_W-1] ? (~w_diff + MAG_W'(1)) : w_diff;

    kci_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == L_DIV_GO),
        .i_dividend (DIV_W'(r_prod)),
        .i_divisor  (i_dur),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    // The quotient is a magnitude, so truncation toward zero comes from the sign applied here.
    assign w_cur_s = SUM_W'(r_cur);
    assign w_quo_s = signed'(SUM_W'(w_quo));
    assign w_sum   = r_neg ? (w_cur_s - w_quo_s) : (w_cur_s + w_quo_s);

    always_comb begin
        priority if (w_sum > SUM_W'(COORD_MAX)) begin
            w_sat = COORD_MAX;
        end else if (w_sum < SUM_W'(COORD_MIN)) begin
            w_sat = COORD_MIN;
        end else begin
            w_sat = w_sum[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_mag   <= w_abs;
                        r_neg   <= w_diff[MAG_W-1];
                        r_cur   <= i_cur;
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_prod  <= PROD_W'(r_mag) * PROD_W'(i_cnt);
                    r_state <= L_DIV_GO;
                end
                L_DIV_GO: begin
                    r_state <= L_DIV_WAIT;
                end
                L_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_state <= L_SUM;
                    end
                end
                L_SUM: begin
                    r_res   <= w_sat;
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
